@@ hw/rtl/bsh_pkg.sv @@
// Shared types and constants for the box smoother with hold and jump lock.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package bsh_pkg;

    // Fixed field widths of the ports
    localparam int BOX_BITS      = 16;
    localparam int GAIN_BITS     = 16;
    localparam int HOLD_BITS     = 8;
    localparam int LOCK_BITS     = 8;
    localparam int JT_BITS       = 16;
    localparam int LIM_BITS      = JT_BITS + 1;
    localparam int LIM_SQ_BITS   = 2 * LIM_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Register reset values
    localparam logic [HOLD_BITS-1:0] RST_HOLD_LIMIT       = 8'd12;
    localparam logic [LOCK_BITS-1:0] RST_LOCK_FRAMES_INIT = 8'd10;
    localparam logic [JT_BITS-1:0]   RST_JUMP_THRESHOLD   = 16'd1920;
    localparam logic [GAIN_BITS-1:0] RST_OVERRIDE_CONF    = 16'd51118;
    localparam logic [GAIN_BITS-1:0] RST_GAIN_HIGH        = 16'd22938;
    localparam logic [GAIN_BITS-1:0] RST_GAIN_LOW         = 16'd13107;
    localparam logic [GAIN_BITS-1:0] RST_GAIN_SELECT      = 16'd45875;
    localparam logic [LIM_SQ_BITS-1:0] RST_LIM_SQ =
        LIM_SQ_BITS'({RST_JUMP_THRESHOLD, 1'b0}) * LIM_SQ_BITS'({RST_JUMP_THRESHOLD, 1'b0});

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_HOLD_LIMIT       = 3'd0,
        CFG_LOCK_FRAMES_INIT = 3'd1,
        CFG_JUMP_THRESHOLD   = 3'd2,
        CFG_OVERRIDE_CONF    = 3'd3,
        CFG_GAIN_HIGH        = 3'd4,
        CFG_GAIN_LOW         = 3'd5,
        CFG_GAIN_SELECT      = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SRC_NONE    = 3'd0,
        SRC_HELD    = 3'd1,
        SRC_ACQUIRE = 3'd2,
        SRC_REJECT  = 3'd3,
        SRC_SMOOTH  = 3'd4
    } t_src;

    typedef struct packed {
        logic                   has_box;
        logic [BOX_BITS-1:0]    box_confidence;
        logic [BOX_BITS-1:0]    box_x;
        logic [BOX_BITS-1:0]    box_y;
        logic [BOX_BITS-1:0]    box_width;
        logic [BOX_BITS-1:0]    box_height;
    } t_box_in;

    typedef struct packed {
        logic                   out_valid;
        logic [BOX_BITS-1:0]    out_confidence;
        logic [BOX_BITS-1:0]    out_x;
        logic [BOX_BITS-1:0]    out_y;
        logic [BOX_BITS-1:0]    out_width;
        logic [BOX_BITS-1:0]    out_height;
        t_src                   source;
    } t_box_out;

    // Register file contents as seen by the datapath
    typedef struct packed {
        logic [HOLD_BITS-1:0]   hold_limit;
        logic [LOCK_BITS-1:0]   lock_frames_init;
        logic [JT_BITS-1:0]     jump_threshold;
        logic [LIM_SQ_BITS-1:0] lim_sq;
        logic [GAIN_BITS-1:0]   override_confidence;
        logic [GAIN_BITS-1:0]   gain_high;
        logic [GAIN_BITS-1:0]   gain_low;
        logic [GAIN_BITS-1:0]   gain_select_level;
    } t_cfg;

endpackage

`default_nettype wire

@@ hw/rtl/bsh_ifs.sv @@
// Valid/ready channel interfaces: box requests in, results out, register writes.
// Payload types come from bsh_pkg.
`default_nettype none

interface bsh_box_if;
    logic             valid;
    logic             ready;
    bsh_pkg::t_box_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsh_result_if;
    logic              valid;
    logic              ready;
    bsh_pkg::t_box_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsh_cfg_if;
    logic                                 valid;
    logic                                 ready;
    bsh_pkg::t_cfg_idx                    index;
    logic [bsh_pkg::CFG_DATA_BITS-1:0]    wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bsh_cfg_regs.sv @@
// Configuration register file; also keeps the squared doubled jump limit.
// Uses bsh_pkg and the bsh_cfg_if interface.
`default_nettype none

module bsh_cfg_regs (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bsh_cfg_if.sink      i_cfg,
    output bsh_pkg::t_cfg o_cfg
);

    bsh_pkg::t_cfg                      r_cfg;
    logic [bsh_pkg::LIM_BITS-1:0]       w_lim;

    assign i_cfg.ready = 1'b1;
    assign w_lim       = {i_cfg.wdata[bsh_pkg::JT_BITS-1:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_limit          <= bsh_pkg::RST_HOLD_LIMIT;
            r_cfg.lock_frames_init    <= bsh_pkg::RST_LOCK_FRAMES_INIT;
            r_cfg.jump_threshold      <= bsh_pkg::RST_JUMP_THRESHOLD;
            r_cfg.lim_sq              <= bsh_pkg::RST_LIM_SQ;
            r_cfg.override_confidence <= bsh_pkg::RST_OVERRIDE_CONF;
            r_cfg.gain_high           <= bsh_pkg::RST_GAIN_HIGH;
            r_cfg.gain_low            <= bsh_pkg::RST_GAIN_LOW;
            r_cfg.gain_select_level   <= bsh_pkg::RST_GAIN_SELECT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bsh_pkg::CFG_HOLD_LIMIT: begin
                    r_cfg.hold_limit <= i_cfg.wdata[bsh_pkg::HOLD_BITS-1:0];
                end
                bsh_pkg::CFG_LOCK_FRAMES_INIT: begin
                    r_cfg.lock_frames_init <= i_cfg.wdata[bsh_pkg::LOCK_BITS-1:0];
                end
                bsh_pkg::CFG_JUMP_THRESHOLD: begin
                    r_cfg.jump_threshold <= i_cfg.wdata[bsh_pkg::JT_BITS-1:0];
                    // limit is compared squared, so square it once here
                    r_cfg.lim_sq <= bsh_pkg::LIM_SQ_BITS'(w_lim) * bsh_pkg::LIM_SQ_BITS'(w_lim);
                end
                bsh_pkg::CFG_OVERRIDE_CONF: begin
                    r_cfg.override_confidence <= i_cfg.wdata[bsh_pkg::GAIN_BITS-1:0];
                end
                bsh_pkg::CFG_GAIN_HIGH: begin
                    r_cfg.gain_high <= i_cfg.wdata[bsh_pkg::GAIN_BITS-1:0];
                end
                bsh_pkg::CFG_GAIN_LOW: begin
                    r_cfg.gain_low <= i_cfg.wdata[bsh_pkg::GAIN_BITS-1:0];
                end
                bsh_pkg::CFG_GAIN_SELECT: begin
                    r_cfg.gain_select_level <= i_cfg.wdata[bsh_pkg::GAIN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hw/rtl/bsh_ema.sv @@
// One field of the moving average: (a*new + (65536-a)*old) >> 16, truncated.
// Uses bsh_pkg for the gain width.
`default_nettype none

module bsh_ema #(
    parameter int W = 16
) (
    input  wire logic [bsh_pkg::GAIN_BITS-1:0] i_gain,
    input  wire logic [W-1:0]                  i_new,
    input  wire logic [W-1:0]                  i_old,
    output logic      [W-1:0]                  o_avg
);

    localparam int GB = bsh_pkg::GAIN_BITS;

    // old*2^16 + a*(new-old) equals the two-product form exactly
    logic signed [W:0]      w_diff;
    logic signed [W+GB:0]   w_prod;
    logic signed [W+GB+1:0] w_total;

    assign w_diff  = $signed({1'b0, i_new}) - $signed({1'b0, i_old});
    assign w_prod  = (W+GB+1)'(w_diff) * (W+GB+1)'($signed({1'b0, i_gain}));
    assign w_total = $signed({2'b00, i_old, {GB{1'b0}}}) + $signed({w_prod[W+GB], w_prod});
    assign o_avg   = w_total[W+GB-1:GB];

endmodule

`default_nettype wire

@@ hw/rtl/bsh_jump_det.sv @@
// Centre jump test on doubled centres against the doubled limit and its square.
// Uses bsh_pkg for limit widths.
`default_nettype none

module bsh_jump_det #(
    parameter int COORD_BITS = 16
) (
    input  wire logic [COORD_BITS-1:0]           i_new_x,
    input  wire logic [COORD_BITS-1:0]           i_new_y,
    input  wire logic [COORD_BITS-1:0]           i_new_w,
    input  wire logic [COORD_BITS-1:0]           i_new_h,
    input  wire logic [COORD_BITS-1:0]           i_old_x,
    input  wire logic [COORD_BITS-1:0]           i_old_y,
    input  wire logic [COORD_BITS-1:0]           i_old_w,
    input  wire logic [COORD_BITS-1:0]           i_old_h,
    input  wire logic [bsh_pkg::JT_BITS-1:0]     i_jump_threshold,
    input  wire logic [bsh_pkg::LIM_SQ_BITS-1:0] i_lim_sq,
    output logic                                 o_jump
);

    localparam int DW = COORD_BITS + 2;
    localparam int LB = bsh_pkg::LIM_BITS;
    localparam int SB = bsh_pkg::LIM_SQ_BITS;
    localparam int CW = (DW > LB) ? DW : LB;

    logic [DW-1:0] w_cx_new, w_cy_new, w_cx_old, w_cy_old;
    logic [DW-1:0] w_dx, w_dy;
    logic [LB-1:0] w_lim;
    logic [LB-1:0] w_dx_n, w_dy_n;
    logic [SB-1:0] w_sq_x, w_sq_y;
    logic [SB:0]   w_sq_sum;
    logic          w_far;

    assign w_cx_new = {1'b0, i_new_x, 1'b0} + DW'(i_new_w);
    assign w_cy_new = {1'b0, i_new_y, 1'b0} + DW'(i_new_h);
    assign w_cx_old = {1'b0, i_old_x, 1'b0} + DW'(i_old_w);
    assign w_cy_old = {1'b0, i_old_y, 1'b0} + DW'(i_old_h);

    assign w_dx = (w_cx_new > w_cx_old) ? (w_cx_new - w_cx_old) : (w_cx_old - w_cx_new);
    assign w_dy = (w_cy_new > w_cy_old) ? (w_cy_new - w_cy_old) : (w_cy_old - w_cy_new);

    assign w_lim = {i_jump_threshold, 1'b0};
    assign w_far = (CW'(w_dx) > CW'(w_lim)) || (CW'(w_dy) > CW'(w_lim));

    // squares only matter when both deltas are within the limit, so they fit LB bits
    assign w_dx_n   = LB'(w_dx);
    assign w_dy_n   = LB'(w_dy);
    assign w_sq_x   = SB'(w_dx_n) * SB'(w_dx_n);
    assign w_sq_y   = SB'(w_dy_n) * SB'(w_dy_n);
    assign w_sq_sum = (SB+1)'(w_sq_x) + (SB+1)'(w_sq_y);

    assign o_jump = w_far || (w_sq_sum > (SB+1)'(i_lim_sq));

endmodule

`default_nettype wire

@@ hw/rtl/box_smoother_with_hold_and_jump_lock_core.sv @@
// Box smoother with hold and jump lock. One box request per cycle is accepted.
// A request is captured in an input register; once the result register is free, a
// single compute stage (jump test, five moving-average multipliers, hold/lock
// counters) updates the tracking state and loads the result register, which
// offers the result on the output channel.
// Since the state closes its loop within that one stage, a new request may
// follow every cycle; the input side stalls only while both the input and the
// result register are full and the result is not being taken. No clearing
// pass after reset. Register writes take effect on the next request; write
// only when idle.
`default_nettype none

module box_smoother_with_hold_and_jump_lock_core #(
    parameter int COORD_BITS = 16,
    parameter int CONF_BITS  = 16,
    parameter int COUNT_BITS = 8
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    bsh_cfg_if.sink       i_cfg,
    bsh_box_if.sink       i_box,
    bsh_result_if.source  o_box
);

    localparam int HW = (COUNT_BITS > bsh_pkg::HOLD_BITS) ? COUNT_BITS : bsh_pkg::HOLD_BITS;
    localparam int LW = (COUNT_BITS > bsh_pkg::LOCK_BITS) ? COUNT_BITS : bsh_pkg::LOCK_BITS;
    localparam int FW = (CONF_BITS > bsh_pkg::GAIN_BITS) ? CONF_BITS : bsh_pkg::GAIN_BITS;

    bsh_pkg::t_cfg     w_cfg;

    // input register
    logic              r_in_vld;
    bsh_pkg::t_box_in  r_in;
    logic              w_adv;
    logic              w_fire;

    // tracking state
    logic                  r_tracking, n_tracking;
    logic [COUNT_BITS-1:0] r_miss, n_miss;
    logic [COUNT_BITS-1:0] r_lock, n_lock;
    logic [CONF_BITS-1:0]  r_held_c, n_held_c;
    logic [COORD_BITS-1:0] r_held_x, n_held_x;
    logic [COORD_BITS-1:0] r_held_y, n_held_y;
    logic [COORD_BITS-1:0] r_held_w, n_held_w;
    logic [COORD_BITS-1:0] r_held_h, n_held_h;

    // result register
    logic              r_out_vld;
    bsh_pkg::t_box_out r_out, n_out;

    logic [CONF_BITS-1:0]          w_c;
    logic [COORD_BITS-1:0]         w_x, w_y, w_w, w_h;
    logic [CONF_BITS-1:0]          w_ema_c;
    logic [COORD_BITS-1:0]         w_ema_x, w_ema_y, w_ema_w, w_ema_h;
    logic [bsh_pkg::GAIN_BITS-1:0] w_gain;
    logic                          w_jump;
    logic                          w_c_over;
    logic                          w_miss_ok;
    logic [COUNT_BITS-1:0]         w_lock_init;
    bsh_pkg::t_src                 w_src;

    bsh_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // handshake: result register frees when empty or taken
    assign w_adv       = !r_out_vld || o_box.ready;
    assign i_box.ready = !r_in_vld || w_adv;
    assign w_fire      = r_in_vld && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_box.ready) begin
            r_in_vld <= i_box.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_box.ready && i_box.valid) begin
            r_in <= i_box.data;
        end
    end

    assign w_c = CONF_BITS'(r_in.box_confidence);
    assign w_x = COORD_BITS'(r_in.box_x);
    assign w_y = COORD_BITS'(r_in.box_y);
    assign w_w = COORD_BITS'(r_in.box_width);
    assign w_h = COORD_BITS'(r_in.box_height);

    bsh_jump_det #(.COORD_BITS(COORD_BITS)) u_jump (
        .i_new_x          (w_x),
        .i_new_y          (w_y),
        .i_new_w          (w_w),
        .i_new_h          (w_h),
        .i_old_x          (r_held_x),
        .i_old_y          (r_held_y),
        .i_old_w          (r_held_w),
        .i_old_h          (r_held_h),
        .i_jump_threshold (w_cfg.jump_threshold),
        .i_lim_sq         (w_cfg.lim_sq),
        .o_jump           (w_jump)
    );

    assign w_gain = (FW'(w_c) > FW'(w_cfg.gain_select_level)) ? w_cfg.gain_high
                                                               : w_cfg.gain_low;
    assign w_c_over = FW'(w_c) >= FW'(w_cfg.override_confidence);

    bsh_ema #(.W(CONF_BITS)) u_ema_c (
        .i_gain (w_gain), .i_new (w_c), .i_old (r_held_c), .o_avg (w_ema_c)
    );
    bsh_ema #(.W(COORD_BITS)) u_ema_x (
        .i_gain (w_gain), .i_new (w_x), .i_old (r_held_x), .o_avg (w_ema_x)
    );
    bsh_ema #(.W(COORD_BITS)) u_ema_y (
        .i_gain (w_gain), .i_new (w_y), .i_old (r_held_y), .o_avg (w_ema_y)
    );
    bsh_ema #(.W(COORD_BITS)) u_ema_w (
        .i_gain (w_gain), .i_new (w_w), .i_old (r_held_w), .o_avg (w_ema_w)
    );
    bsh_ema #(.W(COORD_BITS)) u_ema_h (
        .i_gain (w_gain), .i_new (w_h), .i_old (r_held_h), .o_avg (w_ema_h)
    );

    // hold continues while below the limit and the counter is not saturated
    assign w_miss_ok = r_tracking && (HW'(r_miss) < HW'(w_cfg.hold_limit)) && !(&r_miss);

    // lock reload value saturates to the counter width
    assign w_lock_init = (LW'(w_cfg.lock_frames_init) > LW'({COUNT_BITS{1'b1}}))
                         ? {COUNT_BITS{1'b1}} : COUNT_BITS'(w_cfg.lock_frames_init);

    always_comb begin
        n_tracking = r_tracking;
        n_miss     = r_miss;
        n_lock     = r_lock;
        n_held_c   = r_held_c;
        n_held_x   = r_held_x;
        n_held_y   = r_held_y;
        n_held_w   = r_held_w;
        n_held_h   = r_held_h;
        w_src      = bsh_pkg::SRC_NONE;
        if (!r_in.has_box) begin
            if (w_miss_ok) begin
                n_miss = r_miss + COUNT_BITS'(1);
                w_src  = bsh_pkg::SRC_HELD;
            end else begin
                n_tracking = 1'b0;
                n_miss     = '0;
                n_lock     = '0;
                w_src      = bsh_pkg::SRC_NONE;
            end
        end else begin
            n_miss = '0;
            if (!r_tracking) begin
                n_held_c   = w_c;
                n_held_x   = w_x;
                n_held_y   = w_y;
                n_held_w   = w_w;
                n_held_h   = w_h;
                n_tracking = 1'b1;
                n_lock     = w_lock_init;
                w_src      = bsh_pkg::SRC_ACQUIRE;
            end else if ((r_lock != '0) && w_jump && !w_c_over) begin
                n_lock = r_lock - COUNT_BITS'(1);
                w_src  = bsh_pkg::SRC_REJECT;
            end else begin
                n_held_c = w_ema_c;
                n_held_x = w_ema_x;
                n_held_y = w_ema_y;
                n_held_w = w_ema_w;
                n_held_h = w_ema_h;
                if (!w_jump || w_c_over) begin
                    n_lock = w_lock_init;
                end
                w_src = bsh_pkg::SRC_SMOOTH;
            end
        end

        n_out.source = w_src;
        if (w_src == bsh_pkg::SRC_NONE) begin
            n_out.out_valid      = 1'b0;
            n_out.out_confidence = '0;
            n_out.out_x          = '0;
            n_out.out_y          = '0;
            n_out.out_width      = '0;
            n_out.out_height     = '0;
        end else begin
            n_out.out_valid      = 1'b1;
            n_out.out_confidence = bsh_pkg::BOX_BITS'(n_held_c);
            n_out.out_x          = bsh_pkg::BOX_BITS'(n_held_x);
            n_out.out_y          = bsh_pkg::BOX_BITS'(n_held_y);
            n_out.out_width      = bsh_pkg::BOX_BITS'(n_held_w);
            n_out.out_height     = bsh_pkg::BOX_BITS'(n_held_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking <= 1'b0;
            r_miss     <= '0;
            r_lock     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_fire) begin
                r_tracking <= n_tracking;
                r_miss     <= n_miss;
                r_lock     <= n_lock;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_held_c <= n_held_c;
            r_held_x <= n_held_x;
            r_held_y <= n_held_y;
            r_held_w <= n_held_w;
            r_held_h <= n_held_h;
            r_out    <= n_out;
        end
    end

    assign o_box.valid = r_out_vld;
    assign o_box.data  = r_out;

endmodule

`default_nettype wire

@@ tb/tb_box_smoother_with_hold_and_jump_lock_core.sv @@
// Testbench for box_smoother_with_hold_and_jump_lock_core: drives box requests and register
// writes, predicts each smoothed result in a local tracker and checks it field by field.
// Depends on bsh_pkg, the bsh_*_if interfaces and the core module.
`timescale 1ns / 1ps

module tb_box_smoother_with_hold_and_jump_lock_core;
    import bsh_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsh_cfg_if    cfg_ch ();
    bsh_box_if    box_ch ();
    bsh_result_if res_ch ();

    box_smoother_with_hold_and_jump_lock_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_box   (box_ch),
        .o_box   (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local copy of the register file
    logic [HOLD_BITS-1:0] r_hold;
    logic [LOCK_BITS-1:0] r_lock;
    logic [JT_BITS-1:0]   r_jt;
    logic [GAIN_BITS-1:0] r_ovr, r_gh, r_gl, r_gsel;

    // Tracker state
    logic                 trk_on;
    logic [HOLD_BITS-1:0] miss_cnt;
    logic [LOCK_BITS-1:0] lock_cnt;
    logic [BOX_BITS-1:0]  hc, hx, hy, hw, hh;

    t_box_out expected_boxes[$];
    int       err_count = 0;
    int       cycle_count = 0;

    // Stimulus pacing
    int rx_mode = 0;
    int rx_hold_cycles = 0;
    bit paced = 1'b0;
    int burst_left = 0;
    int miss_run = 0;

    function automatic logic [15:0] ema_q16(input logic [15:0] a, input logic [15:0] nv,
                                            input logic [15:0] ov);
        logic [63:0] acc;
        acc = 64'(a) * 64'(nv) + (64'd65536 - 64'(a)) * 64'(ov);
        return acc[31:16];
    endfunction

    // Advances the tracker by one request and returns the result it gives out
    function automatic t_box_out predict_result(input t_box_in b);
        t_box_out r;
        t_src src;
        longint dx, dy, lim;
        logic [15:0] a;
        bit jump;
        r = '0;
        if (!b.has_box) begin
            if (trk_on && miss_cnt < r_hold && miss_cnt != 8'hff) begin
                miss_cnt++;
                src = SRC_HELD;
            end else begin
                trk_on = 1'b0;
                miss_cnt = '0;
                lock_cnt = '0;
                src = SRC_NONE;
            end
        end else begin
            miss_cnt = '0;
            if (!trk_on) begin
                hc = b.box_confidence;
                hx = b.box_x;
                hy = b.box_y;
                hw = b.box_width;
                hh = b.box_height;
                trk_on = 1'b1;
                lock_cnt = r_lock;
                src = SRC_ACQUIRE;
            end else begin
                // doubled centres avoid the half-pixel
                dx = 2 * longint'(b.box_x) + longint'(b.box_width)
                     - 2 * longint'(hx) - longint'(hw);
                dy = 2 * longint'(b.box_y) + longint'(b.box_height)
                     - 2 * longint'(hy) - longint'(hh);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                lim = 2 * longint'(r_jt);
                jump = (dx > lim) || (dy > lim) || (dx * dx + dy * dy > lim * lim);
                if (lock_cnt != 0 && jump && b.box_confidence < r_ovr) begin
                    lock_cnt--;
                    src = SRC_REJECT;
                end else begin
                    a = (b.box_confidence > r_gsel) ? r_gh : r_gl;
                    hc = ema_q16(a, b.box_confidence, hc);
                    hx = ema_q16(a, b.box_x, hx);
                    hy = ema_q16(a, b.box_y, hy);
                    hw = ema_q16(a, b.box_width, hw);
                    hh = ema_q16(a, b.box_height, hh);
                    if (!jump || b.box_confidence >= r_ovr) lock_cnt = r_lock;
                    src = SRC_SMOOTH;
                end
            end
        end
        if (src != SRC_NONE) begin
            r.out_valid = 1'b1;
            r.out_confidence = hc;
            r.out_x = hx;
            r.out_y = hy;
            r.out_width = hw;
            r.out_height = hh;
        end
        r.source = src;
        return r;
    endfunction

    function automatic t_box_in box_at(input bit has, input logic [15:0] c, input logic [15:0] x,
                                       input logic [15:0] y, input logic [15:0] w,
                                       input logic [15:0] h);
        t_box_in b;
        b.has_box = has;
        b.box_confidence = c;
        b.box_x = x;
        b.box_y = y;
        b.box_width = w;
        b.box_height = h;
        return b;
    endfunction

    function automatic t_box_in rand_box();
        return box_at(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
    endfunction

    function automatic logic [15:0] jitter(input logic [15:0] base, input int span);
        int r, v;
        r = $urandom_range(0, 2 * span);
        v = int'(base) + r - span;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    // Confidence biased toward the gain and override thresholds
    function automatic logic [15:0] pick_conf();
        case ($urandom_range(0, 9))
            0: return r_gsel;
            1: return r_gsel + 16'd1;
            2: return r_ovr;
            3: return r_ovr - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // valid stays high after acceptance so back-to-back requests need no re-raise
    task automatic send_box(input t_box_in b);
        box_ch.valid <= 1'b1;
        box_ch.data  <= b;
        @(posedge i_clk);
        while (!box_ch.ready) @(posedge i_clk);
        expected_boxes.push_back(predict_result(b));
    endtask

    task automatic send_paced(input t_box_in b);
        if (paced) begin
            if (burst_left == 0) begin
                box_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        send_box(b);
    endtask

    task automatic wait_idle();
        box_ch.valid <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_HOLD_LIMIT:       r_hold = val[7:0];
            CFG_LOCK_FRAMES_INIT: r_lock = val[7:0];
            CFG_JUMP_THRESHOLD:   r_jt   = val;
            CFG_OVERRIDE_CONF:    r_ovr  = val;
            CFG_GAIN_HIGH:        r_gh   = val;
            CFG_GAIN_LOW:         r_gl   = val;
            CFG_GAIN_SELECT:      r_gsel = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] hold, input logic [7:0] lock,
                              input logic [15:0] jt, input logic [15:0] ovr,
                              input logic [15:0] gh, input logic [15:0] gl,
                              input logic [15:0] gsel);
        wait_idle();
        write_reg(CFG_HOLD_LIMIT, 16'(hold));
        write_reg(CFG_LOCK_FRAMES_INIT, 16'(lock));
        write_reg(CFG_JUMP_THRESHOLD, jt);
        write_reg(CFG_OVERRIDE_CONF, ovr);
        write_reg(CFG_GAIN_HIGH, gh);
        write_reg(CFG_GAIN_LOW, gl);
        write_reg(CFG_GAIN_SELECT, gsel);
        cfg_ch.valid <= 1'b0;
    endtask

    // Reset register values: acquire, both gains, jump edge cases, hold then drop
    task automatic test_tracking_basics();
        send_box(box_at(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        send_box(box_at(1'b1, 16'd40000, 16'd1000, 16'd1000, 16'd320, 16'd320));
        send_box(box_at(1'b1, 16'd50000, 16'd1010, 16'd990, 16'd330, 16'd310));
        send_box(box_at(1'b1, r_gsel, 16'd1005, 16'd1000, 16'd320, 16'd320));
        // jump exactly at the limit is accepted
        send_box(box_at(1'b1, 16'd30000, hx + r_jt, hy, hw, hh));
        send_box(box_at(1'b1, 16'd30000, hx + r_jt + 16'd1, hy, hw, hh));
        // each axis within limit, but the distance is over
        send_box(box_at(1'b1, 16'd30000, hx + 16'd1400, hy + 16'd1400, hw, hh));
        send_box(box_at(1'b1, r_ovr, hx + 16'd3000, hy, hw, hh));
        send_box(box_at(1'b1, r_ovr - 16'd1, hx + 16'd3000, hy, hw, hh));
        repeat (14) send_box(box_at(1'b0, 16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom)));
    endtask

    // Lock counter runs out, large jumps get smoothed, then re-arms
    task automatic test_jump_lock();
        set_config(8'd12, 8'd2, 16'd100, RST_OVERRIDE_CONF, RST_GAIN_HIGH, RST_GAIN_LOW,
                   RST_GAIN_SELECT);
        send_box(box_at(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_box(box_at(1'b1, 16'd20000, 16'd5000, 16'd5000, 16'd400, 16'd400));
        repeat (4) send_box(box_at(1'b1, 16'd20000, hx + 16'd1000, hy, hw, hh));
        send_box(box_at(1'b1, 16'd20000, hx + 16'd10, hy, hw, hh));
        send_box(box_at(1'b1, 16'd20000, hx + 16'd1000, hy, hw, hh));
    endtask

    task automatic test_config_extremes();
        set_config(8'd0, 8'd0, 16'd0, 16'd0, 16'hffff, 16'd0, 16'd0);
        send_box(box_at(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_box(box_at(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        send_box(box_at(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        send_box(box_at(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_box(box_at(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        send_box(box_at(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));

        set_config(8'hff, 8'hff, 16'hffff, 16'hffff, 16'd0, 16'hffff, 16'hffff);
        send_box(box_at(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_box(box_at(1'b1, 16'hfffe, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        send_box(box_at(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        // full hold: miss counter climbs to its maximum, then lock drops
        repeat (256) send_box(box_at(1'b0, 16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom)));
    endtask

    // Mostly tracks near the held box, with jumps, miss runs and raw noise mixed in
    task automatic random_items(input int n);
        t_box_in b;
        int pick, span;
        for (int i = 0; i < n; i++) begin
            b = rand_box();
            if (miss_run > 0) begin
                b.has_box = 1'b0;
                miss_run--;
            end else begin
                pick = $urandom_range(0, 99);
                span = (r_jt > 16'd8000) ? 2000 : int'(r_jt) / 4 + 2;
                if (pick < 55) begin
                    b.has_box = 1'b1;
                    b.box_confidence = pick_conf();
                    if (trk_on) begin
                        b.box_x = jitter(hx, span);
                        b.box_y = jitter(hy, span);
                        b.box_width = jitter(hw, 32);
                        b.box_height = jitter(hh, 32);
                    end
                end else if (pick < 67) begin
                    b.has_box = 1'b1;
                    b.box_confidence = pick_conf();
                end else if (pick < 80) begin
                    b.has_box = 1'b0;
                    miss_run = $urandom_range(0, (r_hold > 8'd38) ? 40 : int'(r_hold) + 2);
                end
            end
            send_paced(b);
        end
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            set_config(8'($urandom_range(0, 15)), 8'($urandom_range(0, 12)),
                       16'($urandom_range(0, 3000)), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
            rx_mode = ph;
            paced = (ph != 0);
            random_items(110);
        end
    endtask

    // Receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        set_config(8'($urandom_range(0, 10)), 8'($urandom_range(0, 10)),
                   16'($urandom_range(100, 2000)), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
        rx_mode = 0;
        paced = 1'b0;
        rx_hold_cycles = 300;
        random_items(40);
        rx_mode = 2;
        paced = 1'b1;
        random_items(20);
    endtask

    task automatic compare_field(input string name, input logic [15:0] e, input logic [15:0] a);
        if (a !== e) begin
            $error("%s expected %0d got %0d", name, e, a);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_box_out exp_box;
        t_box_out got;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got = res_ch.data;
            if (expected_boxes.size() == 0) begin
                $error("result with no request pending, source %0d", got.source);
                err_count++;
            end else begin
                exp_box = expected_boxes.pop_front();
                compare_field("out_valid", 16'(exp_box.out_valid), 16'(got.out_valid));
                compare_field("out_confidence", exp_box.out_confidence, got.out_confidence);
                compare_field("out_x", exp_box.out_x, got.out_x);
                compare_field("out_y", exp_box.out_y, got.out_y);
                compare_field("out_width", exp_box.out_width, got.out_width);
                compare_field("out_height", exp_box.out_height, got.out_height);
                compare_field("source", 16'(exp_box.source), 16'(got.source));
            end
        end
    end

    // Result-side ready: a long hold-off when asked, otherwise the current stall pattern
    initial begin
        int pat;
        pat = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            pat++;
            if (rx_hold_cycles > 0) begin
                res_ch.ready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                case (rx_mode)
                    1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       res_ch.ready <= 1'($urandom_range(0, 1));
                    3:       res_ch.ready <= ((pat % 7) >= 3);
                    default: res_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        r_hold = RST_HOLD_LIMIT;
        r_lock = RST_LOCK_FRAMES_INIT;
        r_jt   = RST_JUMP_THRESHOLD;
        r_ovr  = RST_OVERRIDE_CONF;
        r_gh   = RST_GAIN_HIGH;
        r_gl   = RST_GAIN_LOW;
        r_gsel = RST_GAIN_SELECT;
        trk_on = 1'b0;
        miss_cnt = '0;
        lock_cnt = '0;
        {hc, hx, hy, hw, hh} = '0;

        i_rst_n      <= 1'b0;
        box_ch.valid <= 1'b0;
        box_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_HOLD_LIMIT;
        cfg_ch.wdata <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_tracking_basics();
        test_jump_lock();
        test_config_extremes();
        test_random_traffic();
        test_output_backpressure();

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
